// ----- rtl/core/avrm_pkg.sv -----
package avrm_pkg;

	localparam int NUM_CELLS_DEF   = 512;
	localparam int NUM_ACTIONS_DEF = 8;

	localparam int CELL_W   = 9;
	localparam int ACT_W    = 3;
	localparam int STEP_W   = 16;
	localparam int VAL_W    = 32;
	localparam int VIS_W    = 16;
	localparam int DISC_W   = 17;
	localparam int POW_BITS = 16;

	localparam int PROD_R_W = 50;
	localparam int PROD_C_W = 49;
	localparam int G_W      = 50;
	localparam int VM_W     = 49;
	localparam int NUM_W    = 52;
	localparam int MAG_W    = 51;
	localparam int DEN_W    = 18;

	localparam logic [DISC_W-1:0] Q_ONE = 17'd65536;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [ACT_W-1:0]  act_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [VIS_W-1:0]  vis_t;

	typedef enum logic {
		OP_READ   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef enum logic {
		REG_DISCOUNT = 1'b0,
		REG_COST     = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_POW,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/avrm_in_if.sv -----
interface avrm_in_if
	import avrm_pkg::*;
();
	logic  valid;
	logic  ready;
	logic  opcode;
	cell_t cell_index;
	act_t  action_index;
	step_t step_taken;
	step_t episode_length;
	val_t  final_reward;

	modport source(output valid, opcode, cell_index, action_index, step_taken,
		episode_length, final_reward, input ready);
	modport sink(input valid, opcode, cell_index, action_index, step_taken,
		episode_length, final_reward, output ready);
endinterface

// ----- rtl/core/avrm_out_if.sv -----
interface avrm_out_if
	import avrm_pkg::*;
();
	logic valid;
	logic ready;
	val_t mean_reward;
	vis_t visit_count;

	modport source(output valid, mean_reward, visit_count, input ready);
	modport sink(input valid, mean_reward, visit_count, output ready);
endinterface

// ----- rtl/core/avrm_div.sv -----
// Restoring divider, one quotient bit per cycle, floor semantics on a signed numerator.
module avrm_div
	import avrm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-2:0]        d,
	output logic                    done,
	output logic signed [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(MAG_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MAG_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [MAG_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   rem_sh;
	logic             qbit;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[MAG_W-1]};
	assign qbit   = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// floor for negatives: q = ~(~num / den)
			neg_q <= num[NUM_W-1];
			quo_q <= num[NUM_W-1] ? ~num[MAG_W-1:0] : num[MAG_W-1:0];
			rem_q <= '0;
			den_q <= {d, 1'b0};
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[MAG_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? ~$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ----- rtl/core/action_value_running_mean_update.sv -----
// Update word: a table read, 16 power steps, 3 multiply stages, the divider run and
// a write-back from accept to result; a read word takes the table read only.
// One word in flight; the result waits until out_ch can take it, and
// the next word is taken the cycle after the result is loaded into the output register.
// Reset clears control registers at once, then sweeps the table to zero, one entry a
// cycle, NUM_CELLS*NUM_ACTIONS entries (4096 by default), taking no words meanwhile.
module action_value_running_mean_update
	import avrm_pkg::*;
#(
	parameter int NUM_CELLS   = NUM_CELLS_DEF,
	parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [VAL_W-1:0]  cfg_data,
	avrm_in_if.sink           in_ch,
	avrm_out_if.source        out_ch
);

	localparam int DEPTH = NUM_CELLS * NUM_ACTIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = VAL_W + VIS_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam int PCW = $clog2(POW_BITS);
	localparam logic [PCW-1:0] POW_LAST = PCW'(POW_BITS - 1);

	state_t state_q, state_d;

	logic [DISC_W-1:0] disc_q;
	val_t              cost_q;

	logic              op_q;
	logic              hit_q;
	logic [AW-1:0]     addr_q;
	step_t             step_q;
	step_t             exp_q;
	val_t              reward_q;
	logic [AW-1:0]     clr_q;

	logic [MW-1:0]     mem [DEPTH];
	logic [MW-1:0]     rdata_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [MW-1:0]     mem_wd;

	logic [PCW-1:0]    pow_cnt_q;
	logic [DISC_W-1:0] p_q, b_q;
	logic [34:0]       pm, bm;

	logic signed [PROD_R_W-1:0] prod_r_q;
	logic signed [PROD_C_W-1:0] prod_c_q;
	logic signed [G_W-1:0]      g_q;
	logic signed [VM_W-1:0]     vm_q;
	logic signed [PROD_R_W-1:0] prod_r_rnd;

	vis_t              v_cur;
	val_t              m_cur;
	logic [VIS_W:0]    d_cur;
	logic [NUM_W-1:0]  num;

	logic                    div_start;
	logic                    div_done;
	logic signed [NUM_W-1:0] quo;
	val_t                    m_sat;
	vis_t                    v_new;

	logic              out_valid_q;
	val_t              out_mean_q;
	vis_t              out_vis_q;
	logic              out_free;
	logic              upd;

	logic [31:0]       idx_full;
	logic              in_hit;

	assign v_cur = rdata_q[MW-1:VAL_W];
	assign m_cur = rdata_q[VAL_W-1:0];
	assign d_cur = {1'b0, v_cur} + 1'b1;
	assign upd   = hit_q && (op_q == OP_UPDATE);

	assign idx_full = 32'(in_ch.cell_index) * 32'(NUM_ACTIONS) + 32'(in_ch.action_index);
	assign in_hit   = (32'(in_ch.cell_index) < 32'(NUM_CELLS)) &&
		(32'(in_ch.action_index) < 32'(NUM_ACTIONS));

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q <= Q_ONE;
			cost_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DISCOUNT: disc_q <= cfg_data[DISC_W-1:0];
				REG_COST:     cost_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		div_start   = 1'b0;
		mem_we      = 1'b0;
		mem_wa      = clr_q;
		mem_wd      = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = upd ? ST_POW : ST_DONE;
			end
			ST_POW: begin
				if (pow_cnt_q == POW_LAST) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
					mem_we  = upd;
					mem_wa  = addr_q;
					mem_wd  = {v_new, m_sat};
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[addr_q];
	end

	// item capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			op_q     <= in_ch.opcode;
			hit_q    <= in_hit;
			addr_q   <= idx_full[AW-1:0];
			step_q   <= in_ch.step_taken;
			exp_q    <= (in_ch.episode_length > in_ch.step_taken) ?
				(in_ch.episode_length - in_ch.step_taken) : '0;
			reward_q <= in_ch.final_reward;
		end
	end

	// discount power, one exponent bit a cycle, LSB first
	assign pm = 35'(p_q) * 35'(b_q) + 35'd32768;
	assign bm = 35'(b_q) * 35'(b_q) + 35'd32768;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			pow_cnt_q <= '0;
			p_q       <= Q_ONE;
			b_q       <= (disc_q > Q_ONE) ? Q_ONE : disc_q;
		end else if (state_q == ST_POW) begin
			pow_cnt_q <= pow_cnt_q + 1'b1;
			if (exp_q[pow_cnt_q]) p_q <= pm[DISC_W+15:16];
			b_q <= bm[DISC_W+15:16];
		end
	end

	assign prod_r_rnd = prod_r_q + PROD_R_W'(32768);

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL1) begin
			prod_r_q <= $signed(reward_q) * $signed({1'b0, p_q});
			prod_c_q <= $signed(cost_q) * $signed({1'b0, step_q});
		end
		if (state_q == ST_MUL2) begin
			g_q  <= (prod_r_rnd >>> 16) + G_W'(prod_c_q);
			vm_q <= $signed({1'b0, v_cur}) * $signed(m_cur);
		end
	end

	// numerator 2n + d over denominator 2d
	assign num = ((NUM_W'(vm_q) + NUM_W'(g_q)) << 1) + NUM_W'(d_cur);

	avrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.d      (d_cur),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		if (quo[NUM_W-1:VAL_W-1] == '0 || quo[NUM_W-1:VAL_W-1] == '1)
			m_sat = quo[VAL_W-1:0];
		else if (quo[NUM_W-1])
			m_sat = {1'b1, {(VAL_W-1){1'b0}}};
		else
			m_sat = {1'b0, {(VAL_W-1){1'b1}}};
	end

	assign v_new = (v_cur == '1) ? v_cur : v_cur + 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			if (!hit_q) begin
				out_mean_q <= '0;
				out_vis_q  <= '0;
			end else if (op_q == OP_UPDATE) begin
				out_mean_q <= m_sat;
				out_vis_q  <= v_new;
			end else begin
				out_mean_q <= m_cur;
				out_vis_q  <= v_cur;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.mean_reward = out_mean_q;
	assign out_ch.visit_count = out_vis_q;

endmodule
